// File: hdl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared widths and types of the halo box partitioner.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int MAX_DIMS   = 3;
  localparam int AXES       = 3;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = 5;
  localparam int AX_W       = 2;
  localparam int IN_W       = ((3 * AXES * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 2 * AXES * COORD_BITS + IDX_W;
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [AX_W-1:0]       axis_idx_t;

  typedef struct packed {
    logic   bad;
    coord_t hi_off;
    coord_t hi_len;
  } axis_res_t;

endpackage

// File: hdl/hbp_axis_unit.sv
// ----------------------------------------------------------------------------
// hbp_axis_unit
// Shared add and compare unit: high cut, high extent and bounds check of one
// axis.
// ----------------------------------------------------------------------------
module hbp_axis_unit (
  input  hbp_pkg::coord_t    top,
  input  hbp_pkg::coord_t    off,
  input  hbp_pkg::coord_t    size,
  output hbp_pkg::axis_res_t res
);

  logic [hbp_pkg::COORD_BITS:0] sum;

  assign sum        = {1'b0, off} + {1'b0, size};
  assign res.bad    = (size == '0) || (sum > {1'b0, top});
  assign res.hi_off = sum[hbp_pkg::COORD_BITS-1:0];
  assign res.hi_len = top - sum[hbp_pkg::COORD_BITS-1:0];

endmodule

// File: hdl/halo_box_partitioner.sv
// ----------------------------------------------------------------------------
// halo_box_partitioner
// Splits an outer box into low, inner and high sub-boxes per axis and emits
// every non-empty combination in lexicographic order, or one error result.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                         tuser        tlast
// s_axis    in   outer_size_0..2, inner_offset_0..2,           -            -
//                inner_size_0..2
// m_axis    out  seg_offset_0..2, seg_size_0..2, seg_index     bad_request  last_segment
// cfg       in   cfg_wr_data = dims_in_use                     -            -
//
// One request is set up one axis per cycle through the shared add/compare
// unit, then steps through the candidate boxes, up to 3^n, one per cycle
// while m_axis is not stalled, with empty candidates skipped.
// A stalled m_axis holds the sequencer; s_axis is ready only when idle.
// rst is synchronous and clears control state; dims_in_use resets to 3.
// ----------------------------------------------------------------------------
module halo_box_partitioner (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_wr_data,   // dims_in_use
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // outer_size_0..2, inner_offset_0..2, inner_size_0..2
  input  logic [hbp_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // seg_offset_0..2, seg_size_0..2, seg_index, zero pad
  output logic [hbp_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tuser,  // bad_request
  output logic                       m_axis_tlast   // last_segment
);

  localparam int C = hbp_pkg::COORD_BITS;
  localparam int A = hbp_pkg::AXES;

  typedef enum logic [1:0] {IDLE, SETUP, BAD, ENUM} state_t;

  state_t               state;
  logic [1:0]           dims;
  hbp_pkg::axis_idx_t   n_act;
  hbp_pkg::axis_idx_t   ax;
  logic                 bad_acc;
  logic [hbp_pkg::IDX_W-1:0] seg_idx;
  hbp_pkg::coord_t      held_outer [A];
  hbp_pkg::coord_t      held_off   [A];
  hbp_pkg::coord_t      held_size  [A];
  hbp_pkg::coord_t      hi_off     [A];
  hbp_pkg::coord_t      hi_len     [A];
  logic [1:0]           digit      [A];
  logic [1:0]           digit_next [A];

  hbp_pkg::axis_idx_t   n_req;
  hbp_pkg::axis_res_t   res;
  hbp_pkg::coord_t      cand_off   [A];
  hbp_pkg::coord_t      cand_len   [A];
  logic                 empty;
  logic                 is_last;
  logic                 out_free;
  logic                 out_load;
  logic [hbp_pkg::OUT_W-1:0] out_word;

  assign s_axis_tready = (state == IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = out_free && ((state == BAD) || ((state == ENUM) && !empty));

  always_comb begin
    if (dims == 2'd0) begin
      n_req = hbp_pkg::AX_W'(1);
    end else if (int'(dims) > hbp_pkg::MAX_DIMS) begin
      n_req = hbp_pkg::AX_W'(hbp_pkg::MAX_DIMS);
    end else begin
      n_req = hbp_pkg::AX_W'(dims);
    end
  end

  hbp_axis_unit u_axis (
    .top  (held_outer[ax]),
    .off  (held_off[ax]),
    .size (held_size[ax]),
    .res  (res)
  );

  always_comb begin
    logic carry;
    logic active;
    empty   = 1'b0;
    is_last = 1'b1;
    carry   = 1'b1;
    out_word = '0;
    for (int k = 0; k < A; k++) begin
      active = (hbp_pkg::AX_W'(k) < n_act);
      unique case (digit[k])
        2'd0: begin
          cand_off[k] = '0;
          cand_len[k] = held_off[k];
        end
        2'd1: begin
          cand_off[k] = held_off[k];
          cand_len[k] = held_size[k];
        end
        default: begin
          cand_off[k] = hi_off[k];
          cand_len[k] = hi_len[k];
        end
      endcase
      if (!active) begin
        cand_off[k] = '0;
        cand_len[k] = '0;
      end
      if (active && cand_len[k] == '0) begin
        empty = 1'b1;
      end
      if (active && digit[k] != ((hi_len[k] != '0) ? 2'd2 : 2'd1)) begin
        is_last = 1'b0;
      end
      out_word[k*C +: C]       = cand_off[k];
      out_word[(A + k)*C +: C] = cand_len[k];
    end
    out_word[2*A*C +: hbp_pkg::IDX_W] = seg_idx;
    for (int k = A - 1; k >= 0; k--) begin
      active = (hbp_pkg::AX_W'(k) < n_act);
      digit_next[k] = digit[k];
      if (active && carry) begin
        if (digit[k] == 2'd2) begin
          digit_next[k] = 2'd0;
        end else begin
          digit_next[k] = digit[k] + 2'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      dims          <= 2'd3;
      m_axis_tvalid <= 1'b0;
      ax            <= '0;
      bad_acc       <= 1'b0;
      seg_idx       <= '0;
      n_act         <= '0;
      for (int k = 0; k < A; k++) begin
        digit[k] <= 2'd0;
      end
    end else begin
      if (cfg_wr_en) begin
        dims <= cfg_wr_data;
      end
      if (m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            for (int k = 0; k < A; k++) begin
              held_outer[k] <= s_axis_tdata[k*C +: C];
              held_off[k]   <= s_axis_tdata[(A + k)*C +: C];
              held_size[k]  <= s_axis_tdata[(2*A + k)*C +: C];
            end
            n_act   <= n_req;
            ax      <= '0;
            bad_acc <= 1'b0;
            state   <= SETUP;
          end
        end
        SETUP: begin
          hi_off[ax] <= res.hi_off;
          hi_len[ax] <= res.hi_len;
          bad_acc    <= bad_acc | res.bad;
          if (ax == n_act - hbp_pkg::AX_W'(1)) begin
            for (int k = 0; k < A; k++) begin
              digit[k] <= 2'd0;
            end
            seg_idx <= '0;
            state   <= (bad_acc | res.bad) ? BAD : ENUM;
          end else begin
            ax <= ax + hbp_pkg::AX_W'(1);
          end
        end
        BAD: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= '0;
            m_axis_tuser  <= 1'b1;
            m_axis_tlast  <= 1'b1;
            state         <= IDLE;
          end
        end
        ENUM: begin
          if (out_free) begin
            for (int k = 0; k < A; k++) begin
              digit[k] <= digit_next[k];
            end
            if (!empty) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= out_word;
              m_axis_tuser  <= 1'b0;
              m_axis_tlast  <= is_last;
              seg_idx       <= seg_idx + hbp_pkg::IDX_W'(1);
              if (is_last) begin
                state <= IDLE;
              end
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("error result without last flag or with payload");

  a_axis0_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[A*C +: C] != '0))
    else $error("empty sub-box emitted");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while enumerating");
`endif

endmodule
